[hw/rtl/iirt_pkg.sv]
package iirt_pkg;

    // sizes of the filter and of its number formats
    localparam int NTAPS        = 64;
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 18;
    localparam int ACC_W        = 40;
    localparam int FRAC         = 14;
    localparam int CNT_W        = 7;
    localparam int COEF_INDEX_W = 6;
    localparam int FUNC_W       = 2;
    localparam int CFG_IDX_W    = 2;

    localparam int IDX_W  = (NTAPS > 1) ? $clog2(NTAPS) : 1;
    localparam int NCNT_W = $clog2(NTAPS + 1);

    // product and sum widths
    localparam int P1_W   = SAMPLE_W + COEF_W;
    localparam int P2_W   = ACC_W + COEF_W;
    localparam int FB_W   = P2_W - FRAC;
    localparam int MAX1_W = (ACC_W > P1_W) ? ACC_W : P1_W;
    localparam int SUM_W  = ((MAX1_W > FB_W) ? MAX1_W : FB_W) + 1;
    localparam int R_W    = ACC_W + 1 - FRAC;
    localparam int OR_W   = ((R_W > SAMPLE_W) ? R_W : SAMPLE_W) + 1;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_BITS = COEF_INDEX_W + COEF_W + SAMPLE_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NUM    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEN    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEN_COUNT = 2'd1;

    typedef struct packed {
        logic signed [ACC_W-1:0]  d;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] a;
    } cell_t;

    typedef struct packed {
        logic pass2;
        logic active;
        logic has_next;
    } tap_ctrl_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
        logic ovf;
        logic signed [ACC_W-1:0] r;
        ovf = (x[SUM_W-1:ACC_W-1] != {(SUM_W - ACC_W + 1){x[SUM_W-1]}});
        if (!ovf) begin
            r = x[ACC_W-1:0];
        end else if (x[SUM_W-1]) begin
            r = {1'b1, {(ACC_W - 1){1'b0}}};
        end else begin
            r = {1'b0, {(ACC_W - 1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [NCNT_W-1:0] used_count(input logic [CNT_W-1:0] c);
        logic [NCNT_W-1:0] r;
        if (c == '0) begin
            r = NCNT_W'(1);
        end else if (int'(c) > NTAPS) begin
            r = NCNT_W'(NTAPS);
        end else begin
            r = NCNT_W'(c);
        end
        return r;
    endfunction

endpackage

[hw/rtl/iirt_cell.sv]
module iirt_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               shift_en,
    input  iirt_pkg::cell_t                    chain_in,
    input  logic                               wr_num,
    input  logic                               wr_den,
    input  logic signed [iirt_pkg::COEF_W-1:0] coef,
    output iirt_pkg::cell_t                    cell_q
);
    import iirt_pkg::*;

    logic signed [ACC_W-1:0]  d_reg;
    logic signed [COEF_W-1:0] b_reg;
    logic signed [COEF_W-1:0] a_reg;

    // delay element, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg <= '0;
        end else if (shift_en) begin
            d_reg <= chain_in.d;
        end
    end

    // coefficients travel round the ring with their delay element
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            b_reg <= chain_in.b;
            a_reg <= chain_in.a;
        end else begin
            if (wr_num) begin
                b_reg <= coef;
            end
            if (wr_den) begin
                a_reg <= coef;
            end
        end
    end

    assign cell_q = '{d: d_reg, b: b_reg, a: a_reg};

endmodule

[hw/rtl/iirt_tap_unit.sv]
module iirt_tap_unit (
    input  iirt_pkg::tap_ctrl_t                  ctrl,
    input  iirt_pkg::cell_t                      head,
    input  logic signed [iirt_pkg::ACC_W-1:0]    next_d,
    input  logic signed [iirt_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [iirt_pkg::ACC_W-1:0]    y,
    output logic signed [iirt_pkg::ACC_W-1:0]    new_d
);
    import iirt_pkg::*;

    logic signed [ACC_W-1:0] src;
    logic signed [P1_W-1:0]  prod1;
    logic signed [SUM_W-1:0] sum1;
    logic signed [P2_W-1:0]  prod2;
    logic signed [P2_W-1:0]  rnd2;
    logic signed [FB_W-1:0]  fb;
    logic signed [SUM_W-1:0] sum2;

    always_comb begin
        // forward pass: shifted element plus sample times numerator
        src   = ctrl.has_next ? next_d : '0;
        prod1 = sample * head.b;
        sum1  = SUM_W'(src) + SUM_W'(prod1);

        // feedback pass: output times denominator, rounded half up to 22 fraction bits
        prod2 = y * head.a;
        rnd2  = prod2 + (P2_W'(1) << (FRAC - 1));
        fb    = $signed(rnd2[P2_W-1:FRAC]);
        sum2  = SUM_W'(head.d) - SUM_W'(fb);

        if (!ctrl.active) begin
            new_d = head.d;
        end else if (ctrl.pass2) begin
            new_d = sat_acc(sum2);
        end else begin
            new_d = sat_acc(sum1);
        end
    end

endmodule

[hw/rtl/iir_transposed_filter_top.sv]
// IIR filter in transposed direct form II on a stream. A sample transfer (tuser 0) gives one
// result transfer; numerator (tuser 1) and denominator (tuser 2) coefficient writes give none
// and leave the input side ready, and tuser 3 is dropped. The delay elements and both
// coefficient tables sit in a ring of NTAPS cells that rotates one place a cycle, while a
// sample is processed, past a single tap unit (one multiply, add and saturate). A sample makes
// two full turns of the ring, one for the forward terms and one for the feedback terms, and
// holds the input side through both turns and the loading of the output register; a waiting
// result stalls only the loading of the next one.
// Samples are Q8.8, coefficients Q4.14, delay elements 40 bits with 22 fraction bits and
// saturating; the output is rounded half up and saturated to 16 bits, with tuser flagging a
// clip. Coefficient tables hold no reset value: write every entry in use before filtering.
// The user writes counts on the config channel only while no sample is in flight; the block itself does not enforce it.
module iir_transposed_filter_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [5:0] coef_index, [23:6] coef_value, [39:24] sample
    input  logic [iirt_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] func
    input  logic [iirt_pkg::FUNC_W-1:0]         s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] filtered
    output logic [iirt_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] saturated
    output logic [0:0]                          m_tuser,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iirt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iirt_pkg::CNT_W-1:0]          cfg_data
);
    import iirt_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PASS1 = 2'd1;
    localparam logic [1:0] ST_PASS2 = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [IDX_W-1:0]           k_reg, k_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [ACC_W-1:0]    y_reg;
    logic [CNT_W-1:0]           num_cnt_reg;
    logic [CNT_W-1:0]           den_cnt_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic                       out_sat_reg;

    // input fields
    logic [FUNC_W-1:0]          in_func;
    logic [COEF_INDEX_W-1:0]    in_idx;
    logic signed [COEF_W-1:0]   in_coef;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic                       in_xfer;

    // counts in use
    logic [NCNT_W-1:0]          n_used;
    logic [NCNT_W-1:0]          den_used;
    logic [NCNT_W-1:0]          m_used;

    // ring and tap unit
    cell_t                      cell_q   [NTAPS];
    cell_t                      chain_in [NTAPS];
    cell_t                      tail;
    tap_ctrl_t                  tap_ctrl;
    logic signed [ACC_W-1:0]    tap_new_d;
    logic                       shift_en;
    logic                       last_k;

    // output rounding
    logic [ACC_W:0]             y_rnd;
    logic signed [R_W-1:0]      y_r;
    logic signed [OR_W-1:0]     y_ext;
    logic                       y_ovf;
    logic [SAMPLE_W-1:0]        y_sat;
    logic                       out_free;

    assign in_func   = s_tuser;
    assign in_idx    = s_tdata[COEF_INDEX_W-1:0];
    assign in_coef   = $signed(s_tdata[COEF_INDEX_W +: COEF_W]);
    assign in_sample = $signed(s_tdata[COEF_INDEX_W + COEF_W +: SAMPLE_W]);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // a count of zero acts as one, above the ring size as the ring size
    assign n_used   = used_count(num_cnt_reg);
    assign den_used = used_count(den_cnt_reg);
    assign m_used   = (den_used < n_used) ? den_used : n_used;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cnt_reg <= CNT_W'(1);
            den_cnt_reg <= CNT_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_NUM_COUNT: num_cnt_reg <= cfg_data;
                REG_DEN_COUNT: den_cnt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ring of cells, cell 0 at the tap unit, the processed element re-entering at the top
    assign shift_en = (state_reg == ST_PASS1) || (state_reg == ST_PASS2);
    assign tail     = '{d: tap_new_d, b: cell_q[0].b, a: cell_q[0].a};

    for (genvar i = 0; i < NTAPS; i++) begin : g_cell
        logic wr_num;
        logic wr_den;

        if (i < NTAPS - 1) begin : g_link
            assign chain_in[i] = cell_q[i + 1];
        end else begin : g_tail
            assign chain_in[i] = tail;
        end

        // an index past the ring matches no cell and the write is dropped
        assign wr_num = in_xfer && (in_func == FUNC_NUM) && (int'(in_idx) == i);
        assign wr_den = in_xfer && (in_func == FUNC_DEN) && (int'(in_idx) == i);

        iirt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .chain_in (chain_in[i]),
            .wr_num   (wr_num),
            .wr_den   (wr_den),
            .coef     (in_coef),
            .cell_q   (cell_q[i])
        );
    end

    // first turn: every element in use takes its upper neighbour (zero for the top one) plus the forward term
    // second turn: elements from 1 up to below the smaller of the two counts lose the feedback term
    always_comb begin
        tap_ctrl.pass2    = (state_reg == ST_PASS2);
        tap_ctrl.has_next = (NCNT_W'(k_reg) + NCNT_W'(1)) < n_used;
        if (state_reg == ST_PASS2) begin
            tap_ctrl.active = (k_reg != '0) && (NCNT_W'(k_reg) < m_used);
        end else begin
            tap_ctrl.active = (NCNT_W'(k_reg) < n_used);
        end
    end

    iirt_tap_unit u_tap (
        .ctrl   (tap_ctrl),
        .head   (cell_q[0]),
        .next_d (cell_q[1 % NTAPS].d),
        .sample (sample_reg),
        .y      (y_reg),
        .new_d  (tap_new_d)
    );

    // sequencer
    assign last_k   = (k_reg == IDX_W'(NTAPS - 1));
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    unique case (in_func)
                        FUNC_SAMPLE: begin
                            state_next = ST_PASS1;
                            k_next     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PASS1: begin
                if (last_k) begin
                    state_next = ST_PASS2;
                    k_next     = '0;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_PASS2: begin
                if (last_k) begin
                    state_next = ST_DONE;
                    k_next     = '0;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // sample held for the forward turn, element 0 captured as the output value
    always_ff @(posedge aclk) begin
        if (in_xfer && (in_func == FUNC_SAMPLE)) begin
            sample_reg <= in_sample;
        end
        if ((state_reg == ST_PASS1) && (k_reg == '0)) begin
            y_reg <= tap_new_d;
        end
    end

    // round element 0 half up to 8 fraction bits, then clip to the sample range
    always_comb begin
        y_rnd = (ACC_W + 1)'(y_reg) + ((ACC_W + 1)'(1) << (FRAC - 1));
        y_r   = $signed(y_rnd[ACC_W:FRAC]);
        y_ext = OR_W'(y_r);
        y_ovf = (y_ext[OR_W-1:SAMPLE_W-1] != {(OR_W - SAMPLE_W + 1){y_ext[OR_W-1]}});
        if (!y_ovf) begin
            y_sat = y_ext[SAMPLE_W-1:0];
        end else if (y_ext[OR_W-1]) begin
            y_sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            out_data_reg <= y_sat;
            out_sat_reg  <= y_ovf;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = M_TDATA_W'(out_data_reg);
    assign m_tuser[0] = out_sat_reg;

endmodule

[hw/rtl/iirt_checker.sv]
module iirt_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [iirt_pkg::FUNC_W-1:0]    s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [iirt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);
    import iirt_pkg::*;

    localparam logic [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a sample clears the input ready after its transfer
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_SAMPLE) |=> !s_tready)
        else $error("input taken during a sample");

    // coefficient writes finish at once
    a_coef_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && ((s_tuser == FUNC_NUM) || (s_tuser == FUNC_DEN)) |=> s_tready)
        else $error("coefficient write held the input");

    // the clip flag comes only with a full-scale value
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            (m_tdata[SAMPLE_W-1:0] == OUT_MAX) || (m_tdata[SAMPLE_W-1:0] == OUT_MIN))
        else $error("clip flag without full-scale value");

endmodule

bind iir_transposed_filter_top iirt_checker u_iirt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
